// ===== hw/rtl/msort_pkg.sv =====
// Shared command and status types for the merge sorter controller and datapath.
`default_nettype none

package msort_pkg;

  // Datapath operation selected by the controller each cycle
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_COLLECT,
    OP_RUN,
    OP_MERGE,
    OP_EMIT_START,
    OP_EMIT
  } msort_op_e;

  typedef struct packed {
    msort_op_e op;
  } msort_cmd_t;

  typedef struct packed {
    logic seq_end;    // marked element transferred this cycle
    logic run_last;   // current merge step writes the last slot of the run
    logic pass_last;  // current run ends at the element count
    logic sort_done;  // run width covers the whole sequence
    logic emit_done;  // final sorted element loaded into the output register
  } msort_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/merge_sorter_top.sv =====
// Top level of the stable ascending merge sorter.
// Usage:
//   Input channel (in_valid_i/in_ready_o) transfers one signed value per
//   cycle with last_i marking the final element of a sequence. Up to
//   MAX_LEN elements are stored; further elements are dropped and every
//   result of that sequence then carries truncated_o.
//   After the marked transfer the block stops taking input and sorts with
//   bottom-up merge passes (run widths 1, 2, 4, ...), ping-ponging between
//   two banks. Each pass moves one element per cycle through the
//   compare-and-write step, after a setup step per run pair and one per
//   pass; ceil(log2 n) passes run.
//   Output channel (out_valid_o/out_ready_i) then transfers the sorted
//   values one per cycle while the receiver is ready, after a read setup
//   step; last_out_o marks the final one. A stalled receiver holds the
//   output register; emitting pauses and resumes without loss. Once the
//   final result is loaded into the output register, the block takes
//   input for the next sequence.
//   Reset (rst_ni low, asynchronous) empties the sequence and drops any
//   pending result; bank contents are not cleared.
`default_nettype none

module merge_sorter_top
  import msort_pkg::*;
#(
  parameter int MAX_LEN     = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  input  wire logic                   last_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [VALUE_WIDTH-1:0]      sorted_value_o,
  output logic                        last_out_o,
  output logic                        truncated_o
);

  msort_cmd_t cmd;
  msort_sts_t sts;

  // Sequencer: decides which datapath operation runs each cycle
  msort_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  // Datapath: banks, merge compare, output register
  msort_dp #(
    .MAX_LEN     (MAX_LEN),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_valid_i     (in_valid_i),
    .value_i        (value_i),
    .last_i         (last_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .sorted_value_o (sorted_value_o),
    .last_out_o     (last_out_o),
    .truncated_o    (truncated_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/msort_ctrl.sv =====
// Sequencer for the merge sorter: collect, merge passes, emit.
`default_nettype none

module msort_ctrl
  import msort_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire msort_sts_t sts_i,
  output msort_cmd_t      cmd_o,
  output logic            in_ready_o
);

  typedef enum logic [2:0] {
    S_COLLECT,
    S_PASS,
    S_RUN,
    S_MERGE,
    S_EMIT_INIT,
    S_EMIT
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_COLLECT;
    end else begin
      case (state_q)
        S_COLLECT: begin
          if (sts_i.seq_end) state_q <= S_PASS;
        end
        S_PASS: begin
          state_q <= sts_i.sort_done ? S_EMIT_INIT : S_RUN;
        end
        S_RUN: begin
          state_q <= S_MERGE;
        end
        S_MERGE: begin
          if (sts_i.run_last) state_q <= sts_i.pass_last ? S_PASS : S_RUN;
        end
        S_EMIT_INIT: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (sts_i.emit_done) state_q <= S_COLLECT;
        end
        default: begin
          state_q <= S_COLLECT;
        end
      endcase
    end
  end

  always_comb begin
    case (state_q)
      S_COLLECT:   cmd_o.op = OP_COLLECT;
      S_RUN:       cmd_o.op = OP_RUN;
      S_MERGE:     cmd_o.op = OP_MERGE;
      S_EMIT_INIT: cmd_o.op = OP_EMIT_START;
      S_EMIT:      cmd_o.op = OP_EMIT;
      default:     cmd_o.op = OP_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_COLLECT);

endmodule

`default_nettype wire

// ===== hw/rtl/msort_dp.sv =====
// Merge sorter datapath: two ping-pong banks, run pointers, output register.
`default_nettype none

module msort_dp
  import msort_pkg::*;
#(
  parameter int MAX_LEN     = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire msort_cmd_t              cmd_i,
  output msort_sts_t                   sts_o,
  input  wire logic                    in_valid_i,
  input  wire logic [VALUE_WIDTH-1:0]  value_i,
  input  wire logic                    last_i,
  input  wire logic                    out_ready_i,
  output logic                         out_valid_o,
  output logic [VALUE_WIDTH-1:0]       sorted_value_o,
  output logic                         last_out_o,
  output logic                         truncated_o
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int WW = CW + 1;
  localparam int SW = CW + 2;

  logic [VALUE_WIDTH-1:0] bank0 [MAX_LEN];
  logic [VALUE_WIDTH-1:0] bank1 [MAX_LEN];
  logic [VALUE_WIDTH-1:0] rd0a_q, rd0b_q, rd1a_q, rd1b_q;
  logic [VALUE_WIDTH-1:0] rd_a, rd_b, merge_data;

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] n_q, lo_q, a_q, b_q, k_q, mid_q, hi_q, e_q;
  logic [WW-1:0] width_q;
  logic          src_q;

  logic [SW-1:0] mid_s, hi_s;
  logic [CW-1:0] mid_c, hi_c, a_d, b_d, k_inc, e_inc, ra, rb;
  logic          fire, room, take_a, merging, load, run_last, pass_last, emit_done;
  logic          we0, we1;
  logic [CW-1:0] wa0;
  logic [VALUE_WIDTH-1:0] wd0;

  logic                   out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0] sorted_q;
  logic                   last_q, trunc_q;

  assign fire    = (cmd_i.op == OP_COLLECT) && in_valid_i;
  assign room    = (count_q < CW'(MAX_LEN));
  assign merging = (cmd_i.op == OP_MERGE);

  // Run bounds, clamped to the element count
  assign mid_s = SW'(lo_q) + SW'(width_q);
  assign hi_s  = SW'(lo_q) + (SW'(width_q) << 1);
  assign mid_c = (mid_s > SW'(n_q)) ? n_q : mid_s[CW-1:0];
  assign hi_c  = (hi_s > SW'(n_q)) ? n_q : hi_s[CW-1:0];

  assign rd_a = src_q ? rd1a_q : rd0a_q;
  assign rd_b = src_q ? rd1b_q : rd0b_q;

  // Left run wins ties, which keeps the sort stable
  assign take_a = (a_q < mid_q) &&
                  ((b_q >= hi_q) || ($signed(rd_a) <= $signed(rd_b)));
  assign merge_data = take_a ? rd_a : rd_b;
  assign a_d   = a_q + CW'(take_a);
  assign b_d   = b_q + CW'(!take_a);
  assign k_inc = k_q + CW'(1);
  assign e_inc = e_q + CW'(1);

  assign run_last  = (k_inc == hi_q);
  assign pass_last = (hi_q == n_q);
  assign load      = (cmd_i.op == OP_EMIT) && (!out_valid_q || out_ready_i);
  assign emit_done = load && (e_inc == n_q);

  assign sts_o.seq_end   = fire && last_i;
  assign sts_o.run_last  = run_last;
  assign sts_o.pass_last = pass_last;
  assign sts_o.sort_done = (width_q >= WW'(n_q));
  assign sts_o.emit_done = emit_done;

  // Read addresses: issue the next heads so the registered data lines up
  always_comb begin
    ra = a_q;
    rb = b_q;
    case (cmd_i.op)
      OP_RUN: begin
        ra = lo_q;
        rb = mid_c;
      end
      OP_MERGE: begin
        ra = a_d;
        rb = b_d;
      end
      OP_EMIT_START: begin
        ra = '0;
      end
      OP_EMIT: begin
        ra = load ? e_inc : e_q;
      end
      default: begin
        ra = a_q;
        rb = b_q;
      end
    endcase
  end

  // Bank 0 takes collected elements; merges write the bank opposite the source
  always_comb begin
    we0 = 1'b0;
    wa0 = count_q;
    wd0 = value_i;
    if (fire && room) begin
      we0 = 1'b1;
    end else if (merging && src_q) begin
      we0 = 1'b1;
      wa0 = k_q;
      wd0 = merge_data;
    end
  end
  assign we1 = merging && !src_q;

  always_ff @(posedge clk_i) begin
    if (we0) bank0[wa0[AW-1:0]] <= wd0;
    rd0a_q <= bank0[ra[AW-1:0]];
    rd0b_q <= bank0[rb[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (we1) bank1[k_q[AW-1:0]] <= merge_data;
    rd1a_q <= bank1[ra[AW-1:0]];
    rd1b_q <= bank1[rb[AW-1:0]];
  end

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (fire) begin
      if (room) count_d = count_q + CW'(1);
      else      ovf_d   = 1'b1;
    end
    if (emit_done) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  assign out_valid_d = load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_COLLECT: begin
        if (fire && last_i) begin
          n_q     <= count_d;
          width_q <= WW'(1);
          lo_q    <= '0;
          src_q   <= 1'b0;
        end
      end
      OP_RUN: begin
        a_q   <= lo_q;
        b_q   <= mid_c;
        k_q   <= lo_q;
        mid_q <= mid_c;
        hi_q  <= hi_c;
      end
      OP_MERGE: begin
        a_q <= a_d;
        b_q <= b_d;
        k_q <= k_inc;
        if (run_last) begin
          lo_q <= pass_last ? '0 : hi_q;
          if (pass_last) begin
            src_q   <= !src_q;
            width_q <= width_q << 1;
          end
        end
      end
      OP_EMIT_START: begin
        e_q <= '0;
      end
      OP_EMIT: begin
        if (load) e_q <= e_inc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sorted_q <= rd_a;
      last_q   <= (e_inc == n_q);
      trunc_q  <= ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = sorted_q;
  assign last_out_o     = last_q;
  assign truncated_o    = trunc_q;

`ifndef ASSERT_OFF
  a_merge_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_MERGE) |-> (k_q < hi_q && a_q <= mid_q && b_q <= hi_q))
    else $error("merge pointers out of run bounds");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_EMIT) |-> (e_q < n_q))
    else $error("emit index beyond element count");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_done |=> (count_q == '0 && !ovf_q))
    else $error("sequence state not cleared after final result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !room |=> (count_q == CW'(MAX_LEN) && ovf_q))
    else $error("dropped element did not flag truncation");
`endif

endmodule

`default_nettype wire
